### rtl/jetr_pkg.sv
// Package: shared types and constants for the Julia escape-time block.
`timescale 1ns / 1ps
package jetr_pkg;
    localparam int OUT_BITS = 13;
    localparam int RAY_OFFSET = 11;
    localparam int BAILOUT = 100;
    localparam logic [1:0] REG_C_REAL = 2'd0;
    localparam logic [1:0] REG_C_IMAG = 2'd1;
    localparam logic [1:0] REG_MAX_ITER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } mul_ctl_t;
endpackage

### rtl/jetr_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
`timescale 1ns / 1ps
module jetr_mul
    import jetr_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mul_ctl_t                   ctl,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic signed [2*WORD_BITS-1:0] p,
    output logic                       done
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [2*WORD_BITS-1:0]    acc_reg, acc_next;
    logic [2*WORD_BITS-1:0]    mcand_reg, mcand_next;
    logic [WORD_BITS-1:0]      mplier_reg, mplier_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [2*WORD_BITS-1:0]    term;

    // last bit of multiplier carries negative weight
    always_comb
    begin
        term = mplier_reg[0] ? mcand_reg : '0;
        if (cnt_reg == CW'(WORD_BITS - 1))
        begin
            term = ~term + 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            cnt_next = '0;
            acc_next = '0;
            mcand_next = {{WORD_BITS{a[WORD_BITS-1]}}, a};
            mplier_next = b;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + term;
            mcand_next = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WORD_BITS - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign p = acc_reg;
    assign done = done_reg;
endmodule

### rtl/julia_escape_time_rays.sv
// Top level: Julia escape-time iteration with ray decomposition coloring.
//   channel | signals                         | direction
//   in      | in_valid, in_stall, z_real/imag | into block
//   out     | out_valid, out_stall, color_code| out of block
//   cfg     | cfg_we, cfg_index, cfg_data     | into block
// Each pass starts three bit-serial multipliers in parallel (ST_UPDATE), waits for
// their products (ST_MUL), then tests and updates (ST_CHECK); a finished item
// returns to idle through ST_DONE. One item at a time.
// Reset is asynchronous, loads c = i, max_iter = 50.
// A result held by out_stall only holds back the final check of the next item.
`timescale 1ns / 1ps
module julia_escape_time_rays
    import jetr_pkg::*;
#(
    parameter int ITER_BITS = 10,
    parameter int WORD_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [WORD_BITS-1:0]        cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WORD_BITS-1:0] z_real,
    input  logic signed [WORD_BITS-1:0] z_imag,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_BITS-1:0]  color_code
);
    localparam int FRAC = WORD_BITS - 8;
    localparam int PW = 2 * WORD_BITS;
    localparam logic [PW+1:0] LIMIT = (PW+2)'(BAILOUT) << (2 * FRAC);
    localparam logic signed [WORD_BITS+1:0] SMAX = (WORD_BITS+2)'((64'd1 << (WORD_BITS-1)) - 1);
    localparam logic signed [WORD_BITS+1:0] SMIN = -SMAX - 1;

    state_t                      state_reg, state_next;
    logic signed [WORD_BITS-1:0] c_re_reg, c_im_reg, re_reg, im_reg;
    logic [ITER_BITS-1:0]        max_reg, i_reg;
    logic signed [OUT_BITS-1:0]  code_reg;
    logic                        ov_reg;
    mul_ctl_t                    mctl;
    logic signed [PW-1:0]        p_rr, p_ii, p_ri;
    logic                        d_rr, d_ii, d_ri;
    logic [PW+1:0]               mag;
    logic signed [PW+1:0]        dre, dim;
    logic signed [WORD_BITS+1:0] nre, nim;
    logic signed [WORD_BITS-1:0] sre, sim;
    logic                        esc, finish, out_free;

    jetr_mul #(.WORD_BITS(WORD_BITS)) u_rr (.clk(clk), .rst_n(rst_n), .ctl(mctl),
        .a(re_reg), .b(re_reg), .p(p_rr), .done(d_rr));
    jetr_mul #(.WORD_BITS(WORD_BITS)) u_ii (.clk(clk), .rst_n(rst_n), .ctl(mctl),
        .a(im_reg), .b(im_reg), .p(p_ii), .done(d_ii));
    jetr_mul #(.WORD_BITS(WORD_BITS)) u_ri (.clk(clk), .rst_n(rst_n), .ctl(mctl),
        .a(re_reg), .b(im_reg), .p(p_ri), .done(d_ri));

    always_comb
    begin
        mag = (PW+2)'(unsigned'(p_rr)) + (PW+2)'(unsigned'(p_ii));
        esc = !(mag < LIMIT);
        finish = (i_reg >= max_reg) || esc;
        out_free = !ov_reg || !out_stall;
        dre = (PW+2)'(p_rr) - (PW+2)'(p_ii);
        dim = (PW+2)'(p_ri) <<< 1;
        nre = (WORD_BITS+2)'(dre >>> FRAC) + (WORD_BITS+2)'(c_re_reg);
        nim = (WORD_BITS+2)'(dim >>> FRAC) + (WORD_BITS+2)'(c_im_reg);
        sre = (nre > SMAX) ? WORD_BITS'(SMAX) : (nre < SMIN) ? WORD_BITS'(SMIN)
                                                             : WORD_BITS'(nre);
        sim = (nim > SMAX) ? WORD_BITS'(SMAX) : (nim < SMIN) ? WORD_BITS'(SMIN)
                                                             : WORD_BITS'(nim);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid && !in_stall) state_next = ST_UPDATE;
            ST_MUL:    if (d_rr && d_ii && d_ri) state_next = ST_CHECK;
            ST_CHECK:  state_next = finish ? (out_free ? ST_DONE : ST_CHECK) : ST_UPDATE;
            ST_UPDATE: state_next = ST_MUL;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mctl.start = 1'b0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_UPDATE: mctl.start = 1'b1;
            ST_MUL, ST_CHECK, ST_DONE: ;
            default:   in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            c_re_reg <= '0;
            c_im_reg <= WORD_BITS'(64'd1 << FRAC);
            max_reg <= ITER_BITS'(50);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_C_REAL:   c_re_reg <= cfg_data;
                    REG_C_IMAG:   c_im_reg <= cfg_data;
                    REG_MAX_ITER: max_reg <= cfg_data[ITER_BITS-1:0];
                    default:      ;
                endcase
            end
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (state_reg == ST_CHECK && finish && out_free)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    // start point loads on accept; multipliers start in ST_UPDATE
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            re_reg <= z_real;
            im_reg <= z_imag;
            i_reg <= '0;
        end
        else if (state_reg == ST_CHECK && !finish)
        begin
            re_reg <= sre;
            im_reg <= sim;
            i_reg <= i_reg + 1'b1;
        end
        if (state_reg == ST_CHECK && finish && out_free)
        begin
            if (i_reg < max_reg)
            begin
                code_reg <= OUT_BITS'({i_reg, 1'b0})
                    + (im_reg[WORD_BITS-1] ? OUT_BITS'(RAY_OFFSET) : OUT_BITS'(0));
            end
            else
            begin
                code_reg <= '1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign color_code = code_reg;
endmodule
